// ===== rtl/mbe_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-count block.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int COORD_W          = 32;
    localparam int STEP_W           = 31;
    localparam int COUNT_W          = 8;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_INDEX_W      = 2;
    localparam int SAT_IN_W         = 66;
    localparam int QUEUE_DEPTH      = 2;
    localparam int FRAC_BITS_DEF    = 28;
    localparam int INDEX_BITS_DEF   = 12;

    localparam logic signed [COORD_W-1:0] ORIGIN_REAL_RST = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] ORIGIN_IMAG_RST = -32'sd402653184;
    localparam logic [STEP_W-1:0]         STEP_RST        = 31'd1048576;
    localparam logic [COUNT_W-1:0]        MAX_ITER_RST    = 8'd255;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [SAT_IN_W-1:0] sat_in_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_REAL = 2'd0,
        CFG_ORIGIN_IMAG = 2'd1,
        CFG_STEP        = 2'd2,
        CFG_MAX_ITER    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        coord_t cr;
        coord_t ci;
    } point_t;

    function automatic coord_t sat_coord(input sat_in_t v);
        sat_in_t hi;
        sat_in_t lo;
        hi = sat_in_t'(coord_t'({1'b0, {(COORD_W-1){1'b1}}}));
        lo = sat_in_t'(coord_t'({1'b1, {(COORD_W-1){1'b0}}}));
        if (v > hi)
        begin
            return coord_t'({1'b0, {(COORD_W-1){1'b1}}});
        end
        else if (v < lo)
        begin
            return coord_t'({1'b1, {(COORD_W-1){1'b0}}});
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/mbe_front.sv =====
// Front end: accepts pixel indexes and forms the complex point c.
`timescale 1ns / 1ps

module mbe_front #(
    parameter int INDEX_BITS = mbe_pkg::INDEX_BITS_DEF,
    parameter int IN_W       = ((2 * INDEX_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_W-1:0]                   s_tdata,
    input  mbe_pkg::coord_t                   origin_real,
    input  mbe_pkg::coord_t                   origin_imag,
    input  logic [mbe_pkg::STEP_W-1:0]        step,
    input  logic                              queue_full,
    output logic                              push,
    output mbe_pkg::point_t                   push_point
);

    localparam int PROD_W = mbe_pkg::STEP_W + INDEX_BITS;
    localparam int SUM_W  = PROD_W + 2;

    logic                       valid_reg;
    logic [PROD_W-1:0]          prod_re_reg;
    logic [PROD_W-1:0]          prod_im_reg;
    logic [PROD_W-1:0]          prod_re_next;
    logic [PROD_W-1:0]          prod_im_next;
    logic signed [SUM_W-1:0]    sum_re;
    logic signed [SUM_W-1:0]    sum_im;
    logic                       accept;

    assign push     = valid_reg && !queue_full;
    assign s_tready = !valid_reg || push;
    assign accept   = s_tvalid && s_tready;

    assign prod_re_next = PROD_W'(step) * PROD_W'(s_tdata[INDEX_BITS-1:0]);
    assign prod_im_next = PROD_W'(step) * PROD_W'(s_tdata[2*INDEX_BITS-1:INDEX_BITS]);

    assign sum_re = $signed({{(SUM_W-mbe_pkg::COORD_W){origin_real[mbe_pkg::COORD_W-1]}},
                             origin_real})
                  + $signed({2'b00, prod_re_reg});
    assign sum_im = $signed({{(SUM_W-mbe_pkg::COORD_W){origin_imag[mbe_pkg::COORD_W-1]}},
                             origin_imag})
                  + $signed({2'b00, prod_im_reg});

    assign push_point.cr = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(sum_re));
    assign push_point.ci = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(sum_im));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

endmodule

// ===== rtl/mbe_queue.sv =====
// Short queue of complex points between the front end and the iteration engine.
`timescale 1ns / 1ps

module mbe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbe_pkg::point_t push_point,
    output logic            full,
    input  logic            pop,
    output mbe_pkg::point_t pop_point,
    output logic            empty
);

    localparam int DEPTH = mbe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbe_pkg::point_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_point = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_point;
        end
    end

endmodule

// ===== rtl/mbe_engine.sv =====
// Back end: iterates z = z*z + c and registers the escape count.
`timescale 1ns / 1ps

module mbe_engine #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mbe_pkg::COUNT_W-1:0] max_iterations,
    input  logic                        queue_empty,
    input  mbe_pkg::point_t             pop_point,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata
);

    localparam int PROD_W   = 2 * mbe_pkg::COORD_W;
    localparam int FOUR_POS = 2 * FRAC_BITS + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    mbe_pkg::coord_t                x_reg;
    mbe_pkg::coord_t                y_reg;
    mbe_pkg::coord_t                cr_reg;
    mbe_pkg::coord_t                ci_reg;
    logic signed [PROD_W-1:0]       xx_reg;
    logic signed [PROD_W-1:0]       yy_reg;
    logic signed [PROD_W-1:0]       xy_reg;
    logic [mbe_pkg::COUNT_W-1:0]    count_reg;
    logic                           out_valid_reg;
    logic [7:0]                     out_data_reg;

    logic [PROD_W-1:0]              mag;
    logic                           escape;
    logic [mbe_pkg::COUNT_W-1:0]    count_next;
    mbe_pkg::coord_t                x2;
    mbe_pkg::coord_t                y2;
    mbe_pkg::coord_t                xy2;
    mbe_pkg::coord_t                diff;
    mbe_pkg::coord_t                x_next;
    mbe_pkg::coord_t                y_next;
    logic                           out_free;

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign mag        = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign escape     = ((mag >> FOUR_POS) != '0);
    assign count_next = count_reg + 1'b1;

    assign x2   = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(xx_reg >>> FRAC_BITS));
    assign y2   = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(yy_reg >>> FRAC_BITS));
    assign xy2  = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(xy_reg >>> (FRAC_BITS - 1)));
    assign diff = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(x2) - mbe_pkg::sat_in_t'(y2));
    assign x_next = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(diff) + mbe_pkg::sat_in_t'(cr_reg));
    assign y_next = mbe_pkg::sat_coord(mbe_pkg::sat_in_t'(xy2) + mbe_pkg::sat_in_t'(ci_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        state_reg <= (max_iterations == '0) ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (escape || count_next == max_iterations)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    x_reg     <= pop_point.cr;
                    y_reg     <= pop_point.ci;
                    cr_reg    <= pop_point.cr;
                    ci_reg    <= pop_point.ci;
                    count_reg <= '0;
                end
            end
            ST_MUL:
            begin
                xx_reg <= x_reg * x_reg;
                yy_reg <= y_reg * y_reg;
                xy_reg <= x_reg * y_reg;
            end
            ST_UPD:
            begin
                if (!escape)
                begin
                    count_reg <= count_next;
                    x_reg     <= x_next;
                    y_reg     <= y_next;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= 8'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/mandelbrot_escape_count.sv =====
// Top level of the Mandelbrot escape-count block: configuration and wiring.
//
//   Channel  | Direction | Payload
//   s_*      | in        | tdata[11:0] column, tdata[23:12] row
//   m_*      | out       | tdata[7:0] escape_count
//   cfg_*    | in        | cfg_index selects register, cfg_data holds value
//
// The front end registers the scaled indexes of a pixel transaction and pushes
// the point into the queue when it is not full. The iteration engine loads a point,
// runs a square stage and an update stage per iteration, then hands off the count.
// Reset loads the default view and clears the queue and all valid flags.
// A stalled output holds the engine; pixels then fill the queue and the front end.
`timescale 1ns / 1ps

module mandelbrot_escape_count #(
    parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = mbe_pkg::INDEX_BITS_DEF,
    parameter int IN_W       = ((2 * INDEX_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_W-1:0]                     s_tdata,    // column, row
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,    // escape_count
    input  logic                                cfg_we,
    input  logic [mbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mbe_pkg::coord_t                origin_real_reg;
    mbe_pkg::coord_t                origin_imag_reg;
    logic [mbe_pkg::STEP_W-1:0]     step_reg;
    logic [mbe_pkg::COUNT_W-1:0]    max_iter_reg;

    logic                           push;
    logic                           pop;
    logic                           queue_full;
    logic                           queue_empty;
    mbe_pkg::point_t                push_point;
    mbe_pkg::point_t                pop_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_real_reg <= mbe_pkg::ORIGIN_REAL_RST;
            origin_imag_reg <= mbe_pkg::ORIGIN_IMAG_RST;
            step_reg        <= mbe_pkg::STEP_RST;
            max_iter_reg    <= mbe_pkg::MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (mbe_pkg::cfg_index_t'(cfg_index))
                mbe_pkg::CFG_ORIGIN_REAL: origin_real_reg <= cfg_data[mbe_pkg::COORD_W-1:0];
                mbe_pkg::CFG_ORIGIN_IMAG: origin_imag_reg <= cfg_data[mbe_pkg::COORD_W-1:0];
                mbe_pkg::CFG_STEP:        step_reg        <= cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_MAX_ITER:    max_iter_reg    <= cfg_data[mbe_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mbe_front #(
        .INDEX_BITS (INDEX_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .origin_real (origin_real_reg),
        .origin_imag (origin_imag_reg),
        .step        (step_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_point  (push_point)
    );

    mbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_point (push_point),
        .full       (queue_full),
        .pop        (pop),
        .pop_point  (pop_point),
        .empty      (queue_empty)
    );

    mbe_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (max_iter_reg),
        .queue_empty    (queue_empty),
        .pop_point      (pop_point),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

// ===== sim/mandelbrot_escape_count_tb.sv =====
// Testbench for mandelbrot_escape_count: predicts each pixel's escape count and checks it.
`timescale 1ns / 1ps

module mandelbrot_escape_count_tb;

    localparam int FRAC        = mbe_pkg::FRAC_BITS_DEF;
    localparam int HOLD_CYCLES = 2000;
    localparam int DRAIN_WAIT  = 2 * 255 + 8;

    class escape_scoreboard;
        localparam longint COORD_MAX = 64'sd2147483647;
        localparam longint COORD_MIN = -64'sd2147483648;
        localparam longint unsigned ESC_LIMIT = 64'd4 << (2 * FRAC);

        mbe_pkg::coord_t            orig_re;
        mbe_pkg::coord_t            orig_im;
        logic [mbe_pkg::STEP_W-1:0] pitch;
        logic [7:0]                 max_iter;
        logic [7:0]                 expected_counts[$];
        int unsigned                mismatches;

        function new();
            orig_re    = mbe_pkg::ORIGIN_REAL_RST;
            orig_im    = mbe_pkg::ORIGIN_IMAG_RST;
            pitch      = mbe_pkg::STEP_RST;
            max_iter   = mbe_pkg::MAX_ITER_RST;
            mismatches = 0;
        endfunction

        function void set_reg(mbe_pkg::cfg_index_t idx, logic [31:0] v);
            case (idx)
                mbe_pkg::CFG_ORIGIN_REAL: orig_re  = v;
                mbe_pkg::CFG_ORIGIN_IMAG: orig_im  = v;
                mbe_pkg::CFG_STEP:        pitch    = v[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_MAX_ITER:    max_iter = v[7:0];
                default:                  ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > COORD_MAX)
            begin
                return COORD_MAX;
            end
            if (v < COORD_MIN)
            begin
                return COORD_MIN;
            end
            return v;
        endfunction

        function logic [7:0] escape_count_of(logic [11:0] col, logic [11:0] row);
            longint            cr;
            longint            ci;
            longint            x;
            longint            y;
            longint            xx;
            longint            yy;
            longint            xy;
            longint unsigned   mag;
            logic [7:0]        cnt;
            bit                escaped;
            int                n;
            cr = clamp32(longint'(orig_re) + longint'({33'd0, pitch}) * longint'({52'd0, col}));
            ci = clamp32(longint'(orig_im) + longint'({33'd0, pitch}) * longint'({52'd0, row}));
            x = cr;
            y = ci;
            cnt = 8'd0;
            escaped = 1'b0;
            for (n = 0; n < max_iter && !escaped; n++)
            begin
                xx = x * x;
                yy = y * y;
                mag = longint'(xx) + longint'(yy);
                if (mag >= ESC_LIMIT)
                begin
                    escaped = 1'b1;
                end
                else
                begin
                    cnt++;
                    xy = x * y;
                    y = clamp32(clamp32(xy >>> (FRAC - 1)) + ci);
                    x = clamp32(clamp32(clamp32(xx >>> FRAC) - clamp32(yy >>> FRAC)) + cr);
                end
            end
            return cnt;
        endfunction

        function void note_pixel(logic [11:0] col, logic [11:0] row);
            expected_counts.push_back(escape_count_of(col, row));
        endfunction

        function void check_count(logic [7:0] actual);
            logic [7:0] want;
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected escape_count transaction: got %0d", actual);
                end
                return;
            end
            want = expected_counts.pop_front();
            if (want !== actual)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("escape_count mismatch: expected %0d, got %0d", want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;      // column, row
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;      // escape_count
    logic                cfg_we;
    mbe_pkg::cfg_index_t cfg_index;
    logic [31:0]         cfg_data;

    bit                  calm;
    bit                  hold_out;
    escape_scoreboard    sb;

    mandelbrot_escape_count i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_pixel(s_tdata[11:0], s_tdata[23:12]);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_count(m_tdata);
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(mbe_pkg::cfg_index_t idx, logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_view(logic [31:0] re, logic [31:0] im, logic [31:0] st,
                            logic [31:0] mx);
        write_reg(mbe_pkg::CFG_ORIGIN_REAL, re);
        write_reg(mbe_pkg::CFG_ORIGIN_IMAG, im);
        write_reg(mbe_pkg::CFG_STEP, st);
        write_reg(mbe_pkg::CFG_MAX_ITER, mx);
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        int          ph;
        int          i;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] st;
        logic [31:0] mx;
        sb        = new();
        calm      = 1'b0;
        hold_out  = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = mbe_pkg::CFG_ORIGIN_REAL;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default view: corners, origin, escape exactly at |z|^2 == 4
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd512, 12'd384);
        send_pixel(12'd511, 12'd384);
        send_pixel(12'd0, 12'd384);
        send_pixel(12'd1024, 12'd384);
        drain();

        // saturating pixel coordinates
        set_view(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd2);
        drain();

        // zero maximum
        set_view(32'h7fff_ffff, 32'h0, 32'h0, 32'd0);
        send_pixel(12'd5, 12'd5);
        send_pixel(12'd4095, 12'd0);
        drain();

        set_view(32'h0, 32'h0, 32'h0, 32'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        set_view(32'h0400_0000, 32'h0, 32'd1, 32'd255);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd4095);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            calm = (ph == 7);
            if (ph == 2)
            begin
                re = $urandom;
                im = $urandom;
                st = {1'b0, 31'($urandom)};
                mx = $urandom_range(1, 255);
            end
            else
            begin
                re = 32'($urandom_range(0, 939524096)) - 32'd671088640;
                im = 32'($urandom_range(0, 805306368)) - 32'd402653184;
                st = $urandom_range(1 << 10, 1 << 18);
                case ($urandom_range(0, 2))
                    0:       mx = $urandom_range(1, 32);
                    1:       mx = 32'd255;
                    default: mx = $urandom_range(33, 254);
                endcase
            end
            if (ph == 4)
            begin
                mx = $urandom_range(1, 16);
            end
            set_view(re, im, st, mx);
            if (ph == 4)
            begin
                hold_out = 1'b1;
            end
            for (i = 0; i < 80; i++)
            begin
                send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
